FILE: sv/signed_int_to_decimal_ascii_core_assert.svh
// Assertion macros for the signed integer to decimal ASCII core.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SITDA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset
`define SITDA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/sitda_pkg.sv
// Shared types, constants and helpers for the decimal ASCII converter.
package sitda_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int CHAR_W          = 6;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

   // Decimal digits in 2^(w-1), the largest magnitude (1233/4096 ~ log10 2)
   function automatic int dec_digits(input int w);
      return (((w - 1) * 1233) >> 12) + 1;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_DIGITS
   } sitda_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic conv_shift;
      logic drop_digit;
      logic emit_sign;
      logic emit_digit;
   } sitda_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_bit;
      logic top_zero;
      logic rem_one;
      logic negative;
      logic out_free;
   } sitda_status_type;

endpackage

FILE: sv/sitda_ctrl.sv
// Sequencing state machine: conversion, leading-zero drop and character output.
module sitda_ctrl
   import sitda_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  sitda_status_type status,
   output sitda_cmd_type    cmd
);

   sitda_state_type state_ff;
   sitda_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (status.last_bit) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!(status.top_zero && !status.rem_one)) begin
               state_in = status.negative ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (status.out_free && status.rem_one) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CONV: begin
            cmd.conv_shift = 1'b1;
         end
         ST_SKIP: begin
            cmd.drop_digit = status.top_zero && !status.rem_one;
         end
         ST_SIGN: begin
            cmd.emit_sign = status.out_free;
         end
         ST_DIGITS: begin
            cmd.emit_digit = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

FILE: sv/sitda_dpath.sv
// Datapath: magnitude, shift-and-add-3 BCD register and output character register.
module sitda_dpath
   import sitda_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [VALUE_WIDTH-1:0] value,
   input  sitda_cmd_type          cmd,
   output sitda_status_type       status,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [CHAR_W-1:0]      out_char,
   output logic                   out_last
);

   localparam int NDIG  = dec_digits(VALUE_WIDTH);
   localparam int BCD_W = NDIG * 4;
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
   localparam int REM_W = $clog2(NDIG + 1);

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;
   logic [CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]      out_char_ff, out_char_in;
   logic                   out_last_ff, out_last_in;

   logic [BCD_W-1:0]       bcd_adj;
   logic [3:0]             top_digit;

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   // Add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < NDIG; d++) begin
         if (bcd_ff[d*4 +: 4] >= 4'd5) begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4];
         end
      end
   end

   // Conversion registers
   always_comb begin
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      neg_in     = neg_ff;
      bit_cnt_in = bit_cnt_ff;
      rem_in     = rem_ff;
      if (cmd.load) begin
         neg_in     = value[VALUE_WIDTH-1];
         mag_in     = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
         bcd_in     = '0;
         bit_cnt_in = CNT_W'(VALUE_WIDTH);
         rem_in     = REM_W'(NDIG);
      end else if (cmd.conv_shift) begin
         bcd_in     = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - CNT_W'(1);
      end else if (cmd.drop_digit || cmd.emit_digit) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
         rem_in = rem_ff - REM_W'(1);
      end
   end

   // Output character register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit_sign) begin
         out_valid_in = 1'b1;
         out_char_in  = CHAR_MINUS;
         out_last_in  = 1'b0;
      end else if (cmd.emit_digit) begin
         out_valid_in = 1'b1;
         out_char_in  = CHAR_ZERO + {2'b00, top_digit};
         out_last_in  = (rem_ff == REM_W'(1));
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         bit_cnt_ff   <= '0;
         rem_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         bit_cnt_ff   <= bit_cnt_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // Status back to the controller
   assign status.last_bit = (bit_cnt_ff == CNT_W'(1));
   assign status.top_zero = (top_digit == 4'd0);
   assign status.rem_one  = (rem_ff == REM_W'(1));
   assign status.negative = neg_ff;
   assign status.out_free = !out_valid_ff || out_ready;

   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign out_last  = out_last_ff;

endmodule

FILE: sv/signed_int_to_decimal_ascii_core.sv
// Steps: accept, then shift the magnitude bit by bit through the BCD register, then drop
// leading zeros, then emit a minus sign for a negative value, then emit the digits.
// Characters leave at one per cycle while rsp_tready is high; the conversion is done by the
// bit-serial binary-to-BCD shift register.
// A new item is taken while the final character still waits in the output register.
// Synchronous active-high reset clears the controller and the output valid; no memory to clear.
module signed_int_to_decimal_ascii_core
   import sitda_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    req_tdata,   // value, zero padding above
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // out_char [5:0], zeros [7:6]
   output logic                                rsp_tlast    // is_last
);

`include "signed_int_to_decimal_ascii_core_assert.svh"

   sitda_cmd_type    cmd;
   sitda_status_type status;
   logic [CHAR_W-1:0] out_char;

   sitda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sitda_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .value     (req_tdata[VALUE_WIDTH-1:0]),
      .cmd       (cmd),
      .status    (status),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (out_char),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_char};

   // Checks
   `SITDA_ASSERT_NOW(a_cmd_onehot, clock, reset, 1'b1,
      $onehot0({cmd.load, cmd.conv_shift, cmd.drop_digit, cmd.emit_sign, cmd.emit_digit}),
      "more than one datapath command")
   `SITDA_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit_sign || cmd.emit_digit,
      status.out_free, "character emitted over a pending transfer")
   `SITDA_ASSERT_NOW(a_accept_last, clock, reset, req_tvalid && req_tready && rsp_tvalid,
      rsp_tlast, "new value taken while its predecessor is mid-text")
   `SITDA_ASSERT_NEXT(a_run_continues, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid, "gap inside a character run")

endmodule
